FILE: hdl/bytecode_container_deframer_macros.svh
// assertion macros shared by the deframer modules
`ifndef BYTECODE_CONTAINER_DEFRAMER_MACROS_SVH
`define BYTECODE_CONTAINER_DEFRAMER_MACROS_SVH

// same-cycle implication, checked out of reset
`define BCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bcd_pkg.sv
// shared types and constants of the bytecode container deframer
package bcd_pkg;

    // byte that selects big endian order at image start
    localparam logic [7:0] ASCII_T = 8'h74;

    // register indexes on the configuration port
    localparam logic [1:0] REG_UNIT_TAG   = 2'd0;
    localparam logic [1:0] REG_OBJECT_TAG = 2'd1;
    localparam logic [1:0] REG_END_TAG    = 2'd2;

    // parse phase, one-hot
    typedef enum logic [10:0] {
        PH_IDLE   = 11'b000_0000_0001,
        PH_UTAG   = 11'b000_0000_0010,
        PH_VER    = 11'b000_0000_0100,
        PH_ENTRY  = 11'b000_0000_1000,
        PH_RTAG   = 11'b000_0001_0000,
        PH_QUAL   = 11'b000_0010_0000,
        PH_HANDLE = 11'b000_0100_0000,
        PH_LEN    = 11'b000_1000_0000,
        PH_PAY    = 11'b001_0000_0000,
        PH_DONE   = 11'b010_0000_0000,
        PH_ERR    = 11'b100_0000_0000
    } t_phase;

    typedef enum logic [1:0] {
        EV_OBJ_HDR   = 2'd0,
        EV_PAYLOAD   = 2'd1,
        EV_UNIT_DONE = 2'd2,
        EV_ERROR     = 2'd3
    } t_event_kind;

    // unit tag code also encodes the all-zero field outside errors
    typedef enum logic [1:0] {
        ERR_UNIT_TAG   = 2'd0,
        ERR_RECORD_TAG = 2'd1,
        ERR_TRUNCATED  = 2'd2
    } t_err_code;

    typedef struct packed {
        logic [31:0] unit_tag;
        logic [31:0] object_tag;
        logic [31:0] end_tag;
    } t_cfg;

    typedef struct packed {
        t_event_kind kind;
        logic [31:0] obj_handle;
        logic [31:0] obj_qualifiers;
        logic [31:0] obj_length;
        logic        msb_first;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [31:0] entry_handle;
        t_err_code   error_code;
    } t_result;

endpackage

FILE: hdl/bcd_apb_regs.sv
// configuration register file behind the apb port
module bcd_apb_regs import bcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [31:0] r_unit_tag;
    logic [31:0] r_object_tag;
    logic [31:0] r_end_tag;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    // register writes, index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_tag   <= '0;
            r_object_tag <= '0;
            r_end_tag    <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_UNIT_TAG:   r_unit_tag   <= pwdata;
                REG_OBJECT_TAG: r_object_tag <= pwdata;
                REG_END_TAG:    r_end_tag    <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_UNIT_TAG:   prdata = r_unit_tag;
            REG_OBJECT_TAG: prdata = r_object_tag;
            REG_END_TAG:    prdata = r_end_tag;
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.unit_tag   = r_unit_tag;
    assign o_cfg.object_tag = r_object_tag;
    assign o_cfg.end_tag    = r_end_tag;

endmodule

FILE: hdl/bcd_parser.sv
// input register, parse state and one-step field decode
`include "bytecode_container_deframer_macros.svh"
module bcd_parser import bcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_byte,
    input  logic       i_s_first,
    input  logic       i_s_last,
    input  logic       i_out_free,
    output logic       o_load,
    output t_result    o_res
);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_first;
    logic        r_in_last;

    // parse state
    t_phase      r_phase;
    logic [1:0]  r_bif;
    logic [31:0] r_wa;
    logic        r_order;
    logic [31:0] r_rem;
    logic [31:0] r_qual;
    logic [31:0] r_hdl;
    logic [31:0] r_entry;

    // state after an optional restart
    t_phase      s_phase;
    logic [1:0]  s_bif;
    logic [31:0] s_wa;
    logic        s_order;
    logic [31:0] s_rem;
    logic [31:0] s_qual;
    logic [31:0] s_hdl;
    logic [31:0] s_entry;

    // next state
    t_phase      n_phase;
    logic [1:0]  n_bif;
    logic [31:0] n_wa;
    logic [31:0] n_rem;
    logic [31:0] n_qual;
    logic [31:0] n_hdl;
    logic [31:0] n_entry;

    logic        advance;
    logic        active;
    logic        have;
    logic [31:0] base;
    logic [31:0] word;
    t_result     res;

    assign advance    = r_in_valid & i_out_free;
    assign o_s_tready = ~r_in_valid | advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte  <= i_s_byte;
            r_in_first <= i_s_first;
            r_in_last  <= i_s_last;
        end
    end

    // bytes outside an image are dropped unless they start one
    assign active = r_in_first | (r_phase inside {PH_UTAG, PH_VER, PH_ENTRY, PH_RTAG,
                                                  PH_QUAL, PH_HANDLE, PH_LEN, PH_PAY});

    // restart on a first mark
    always_comb begin
        s_phase = r_phase;
        s_bif   = r_bif;
        s_wa    = r_wa;
        s_order = r_order;
        s_rem   = r_rem;
        s_qual  = r_qual;
        s_hdl   = r_hdl;
        s_entry = r_entry;
        if (r_in_first) begin
            s_phase = PH_UTAG;
            s_bif   = '0;
            s_wa    = '0;
            s_order = (r_in_byte == ASCII_T);
            s_rem   = '0;
            s_qual  = '0;
            s_hdl   = '0;
            s_entry = '0;
        end
    end

    // word assembly in the selected byte order
    always_comb begin
        base = (s_bif == 2'd0) ? 32'd0 : s_wa;
        if (s_order) begin
            word = {base[23:0], r_in_byte};
        end else begin
            word = base | ({24'd0, r_in_byte} << {s_bif, 3'b000});
        end
    end

    // field decode and result
    always_comb begin
        n_phase = s_phase;
        n_bif   = s_bif;
        n_wa    = s_wa;
        n_rem   = s_rem;
        n_qual  = s_qual;
        n_hdl   = s_hdl;
        n_entry = s_entry;
        have    = 1'b0;
        res     = '0;
        res.kind       = EV_OBJ_HDR;
        res.error_code = ERR_UNIT_TAG;

        if (s_phase == PH_PAY) begin
            // payload byte passes through
            have             = 1'b1;
            res.kind         = EV_PAYLOAD;
            res.payload_byte = r_in_byte;
            res.payload_last = (s_rem == 32'd1);
            n_rem            = s_rem - 32'd1;
            if (s_rem == 32'd1) begin
                n_phase = PH_RTAG;
            end
        end else begin
            n_wa  = word;
            n_bif = s_bif + 2'd1;
            if (s_bif == 2'd3) begin
                case (s_phase)
                    PH_UTAG: begin
                        if (word != i_cfg.unit_tag) begin
                            have           = 1'b1;
                            res.kind       = EV_ERROR;
                            res.error_code = ERR_UNIT_TAG;
                            n_phase        = PH_ERR;
                        end else begin
                            n_phase = PH_VER;
                        end
                    end
                    PH_VER: n_phase = PH_ENTRY;
                    PH_ENTRY: begin
                        n_entry = word;
                        n_phase = PH_RTAG;
                    end
                    PH_RTAG: begin
                        // end tag wins over object tag
                        if (word == i_cfg.end_tag) begin
                            have             = 1'b1;
                            res.kind         = EV_UNIT_DONE;
                            res.entry_handle = s_entry;
                            n_phase          = PH_DONE;
                        end else if (word == i_cfg.object_tag) begin
                            n_phase = PH_QUAL;
                        end else begin
                            have           = 1'b1;
                            res.kind       = EV_ERROR;
                            res.error_code = ERR_RECORD_TAG;
                            n_phase        = PH_ERR;
                        end
                    end
                    PH_QUAL: begin
                        n_qual  = word;
                        n_phase = PH_HANDLE;
                    end
                    PH_HANDLE: begin
                        n_hdl   = word;
                        n_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        have           = 1'b1;
                        res.kind       = EV_OBJ_HDR;
                        res.obj_length = word;
                        n_rem          = word;
                        n_phase        = (word == 32'd0) ? PH_RTAG : PH_PAY;
                    end
                    default: n_phase = s_phase;
                endcase
            end
        end

        // image ends before it is complete
        if (r_in_last && n_phase != PH_DONE && n_phase != PH_ERR) begin
            have           = 1'b1;
            res.kind       = EV_ERROR;
            res.error_code = ERR_TRUNCATED;
            n_phase        = PH_ERR;
        end

        // errors clear the length, payload and entry fields, other events carry no code
        if (res.kind == EV_ERROR) begin
            res.obj_length   = '0;
            res.payload_byte = '0;
            res.payload_last = 1'b0;
            res.entry_handle = '0;
        end else begin
            res.error_code = ERR_UNIT_TAG;
        end

        res.obj_handle     = n_hdl;
        res.obj_qualifiers = n_qual;
        res.msb_first      = s_order;
    end

    // parse state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bif   <= '0;
            r_wa    <= '0;
            r_order <= 1'b0;
            r_rem   <= '0;
            r_qual  <= '0;
            r_hdl   <= '0;
            r_entry <= '0;
        end else if (advance && active) begin
            r_phase <= n_phase;
            r_bif   <= n_bif;
            r_wa    <= n_wa;
            r_order <= s_order;
            r_rem   <= n_rem;
            r_qual  <= n_qual;
            r_hdl   <= n_hdl;
            r_entry <= n_entry;
        end
    end

    assign o_load = advance & active & have;
    assign o_res  = res;

    // checks
    `BCD_ASSERT_NEXT(a_idle_byte_no_change, i_clk, i_rst_n,
                     advance && !active,
                     $stable(r_phase),
                     "dropped item changed the phase")
    `BCD_ASSERT_NEXT(a_last_payload_to_tag, i_clk, i_rst_n,
                     advance && r_phase == PH_PAY && !r_in_first && !r_in_last
                         && r_rem == 32'd1,
                     r_phase == PH_RTAG,
                     "final payload byte did not return to record tag")

endmodule

FILE: hdl/bcd_out_stage.sv
// result register toward the output stream
`include "bytecode_container_deframer_macros.svh"
module bcd_out_stage import bcd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    input  logic    i_m_tready,
    output logic    o_m_tvalid,
    output t_result o_res
);

    logic    r_out_valid;
    t_result r_out;

    assign o_free     = ~r_out_valid | i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_res      = r_out;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_free) begin
            r_out_valid <= i_load;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_out <= i_res;
        end
    end

    // checks
    `BCD_ASSERT_NOW(a_error_fields_clear, i_clk, i_rst_n, r_out_valid && r_out.kind == EV_ERROR, r_out.obj_length == 32'd0 && r_out.entry_handle == 32'd0 && r_out.payload_byte == 8'd0 && !r_out.payload_last, "error item carries stray fields")
    `BCD_ASSERT_NOW(a_code_only_on_error, i_clk, i_rst_n, r_out_valid && r_out.kind != EV_ERROR, r_out.error_code == ERR_UNIT_TAG, "error code set on a non-error item")

endmodule

FILE: hdl/bytecode_container_deframer.sv
// top level of the bytecode container deframer
// Takes an image one byte per item and emits object headers, payload bytes, a
// unit-complete item with the entry handle, or an error item. A byte marked first
// (s_axis_tuser) restarts parsing; a byte marked last (s_axis_tlast) that leaves the
// image unfinished gives a truncation error. Throughput is one byte per clock cycle
// while the output is not stalled; an item passes an input register, one decode step
// and a result register. Bytes that start no image and belong to none (idle, done,
// error) give no item. Tag registers are to be written over the apb port only while
// the stream is idle; the block itself does not enforce this.
module bytecode_container_deframer import bcd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // image bytes
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] first_byte
    input  logic         s_axis_tlast,   // last_byte
    // parse events
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] obj_handle, [63:32] obj_qualifiers, [95:64] obj_length, [96] msb_first,
    // [104:97] payload_byte, [136:105] entry_handle, [138:137] error_code, rest zero
    output logic [143:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // [1:0] event_kind
    output logic         m_axis_tlast    // payload_last
);

    t_cfg    cfg;
    t_result res;
    t_result out_res;
    logic    load;
    logic    out_free;

    bcd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bcd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_byte   (s_axis_tdata),
        .i_s_first  (s_axis_tuser),
        .i_s_last   (s_axis_tlast),
        .i_out_free (out_free),
        .o_load     (load),
        .o_res      (res)
    );

    bcd_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_res      (res),
        .o_free     (out_free),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_res      (out_res)
    );

    // pack the result item onto the stream
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.payload_last;
    assign m_axis_tdata = {5'd0,
                           out_res.error_code,
                           out_res.entry_handle,
                           out_res.payload_byte,
                           out_res.msb_first,
                           out_res.obj_length,
                           out_res.obj_qualifiers,
                           out_res.obj_handle};

endmodule

FILE: dv/tb_bytecode_container_deframer.sv
// self-checking testbench for the bytecode container deframer
module tb_bytecode_container_deframer import bcd_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RESET_CYCLES    = 12;
    localparam int unsigned CYCLE_LIMIT     = 500000;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned HOLD_OFF_CYCLES = 150;
    localparam int unsigned PHASE_BYTES     = 130;
    localparam int unsigned TAG_SETTINGS    = 6;

    // shapes of generated images
    typedef enum logic [2:0] {
        SHAPE_CLEAN,
        SHAPE_CUT,
        SHAPE_BAD_UNIT,
        SHAPE_BAD_RECORD,
        SHAPE_ABANDONED
    } t_image_shape;

    typedef struct packed {
        logic [7:0] data;
        logic       first_mark;
        logic       last_mark;
    } t_image_byte;

    // predicts parse events from accepted image bytes and checks the block's items
    class deframe_scoreboard;
        t_cfg        tags;
        t_phase      parse_phase;
        logic [1:0]  field_pos;
        logic [31:0] word_acc;
        logic [31:0] pay_left;
        logic [31:0] qual_hold;
        logic [31:0] handle_hold;
        logic [31:0] entry_hold;
        logic        big_end;
        t_result     expected_events[$];
        int unsigned mismatches;

        function new();
            tags = '0;
            mismatches = 0;
            clear_image();
        endfunction

        function void clear_image();
            parse_phase = PH_IDLE;
            field_pos = '0;
            word_acc = '0;
            pay_left = '0;
            qual_hold = '0;
            handle_hold = '0;
            entry_hold = '0;
            big_end = 1'b0;
        endfunction

        function void set_tag(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_UNIT_TAG:   tags.unit_tag = value;
                REG_OBJECT_TAG: tags.object_tag = value;
                REG_END_TAG:    tags.end_tag = value;
                default: ;
            endcase
        endfunction

        // one accepted image byte
        function void note_byte(logic [7:0] b, logic first_mark, logic last_mark);
            t_result ev;
            bit      emit;
            emit = 1'b0;
            ev = '0;
            if (first_mark) begin
                clear_image();
                big_end = (b == ASCII_T);
                parse_phase = PH_UTAG;
            end else if (parse_phase inside {PH_IDLE, PH_DONE, PH_ERR}) begin
                return;
            end

            if (parse_phase == PH_PAY) begin
                emit = 1'b1;
                ev.kind = EV_PAYLOAD;
                ev.payload_byte = b;
                ev.payload_last = (pay_left == 32'd1);
                pay_left = pay_left - 32'd1;
                if (pay_left == 32'd0) parse_phase = PH_RTAG;
            end else begin
                // assemble a 32-bit field in the detected byte order
                if (field_pos == 2'd0) word_acc = '0;
                if (big_end) word_acc = {word_acc[23:0], b};
                else word_acc[8*field_pos +: 8] = b;
                if (field_pos == 2'd3) begin
                    case (parse_phase)
                        PH_UTAG: begin
                            if (word_acc != tags.unit_tag) begin
                                emit = 1'b1;
                                ev.kind = EV_ERROR;
                                ev.error_code = ERR_UNIT_TAG;
                                parse_phase = PH_ERR;
                            end else begin
                                parse_phase = PH_VER;
                            end
                        end
                        PH_VER: parse_phase = PH_ENTRY;
                        PH_ENTRY: begin
                            entry_hold = word_acc;
                            parse_phase = PH_RTAG;
                        end
                        PH_RTAG: begin
                            // end tag wins over a colliding object tag
                            if (word_acc == tags.end_tag) begin
                                emit = 1'b1;
                                ev.kind = EV_UNIT_DONE;
                                ev.entry_handle = entry_hold;
                                parse_phase = PH_DONE;
                            end else if (word_acc == tags.object_tag) begin
                                parse_phase = PH_QUAL;
                            end else begin
                                emit = 1'b1;
                                ev.kind = EV_ERROR;
                                ev.error_code = ERR_RECORD_TAG;
                                parse_phase = PH_ERR;
                            end
                        end
                        PH_QUAL: begin
                            qual_hold = word_acc;
                            parse_phase = PH_HANDLE;
                        end
                        PH_HANDLE: begin
                            handle_hold = word_acc;
                            parse_phase = PH_LEN;
                        end
                        default: begin
                            emit = 1'b1;
                            ev.kind = EV_OBJ_HDR;
                            ev.obj_length = word_acc;
                            pay_left = word_acc;
                            parse_phase = (word_acc == 32'd0) ? PH_RTAG : PH_PAY;
                        end
                    endcase
                end
                field_pos = field_pos + 2'd1;
            end

            // last byte of an unfinished image replaces whatever it gave
            if (last_mark && !(parse_phase inside {PH_DONE, PH_ERR})) begin
                emit = 1'b1;
                ev = '0;
                ev.kind = EV_ERROR;
                ev.error_code = ERR_TRUNCATED;
                parse_phase = PH_ERR;
            end

            if (!emit) return;
            ev.obj_handle = handle_hold;
            ev.obj_qualifiers = qual_hold;
            ev.msb_first = big_end;
            expected_events.push_back(ev);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // one accepted parse event
        function void check_event(t_result got);
            t_result want;
            if (expected_events.size() == 0) begin
                $display("%0t: event with none expected, expected nothing, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = expected_events.pop_front();
            compare_field("event_kind", want.kind, got.kind);
            compare_field("obj_handle", want.obj_handle, got.obj_handle);
            compare_field("obj_qualifiers", want.obj_qualifiers, got.obj_qualifiers);
            compare_field("obj_length", want.obj_length, got.obj_length);
            compare_field("msb_first", want.msb_first, got.msb_first);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("payload_last", want.payload_last, got.payload_last);
            compare_field("entry_handle", want.entry_handle, got.entry_handle);
            compare_field("error_code", want.error_code, got.error_code);
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;   // [7:0] data_byte
    logic         s_axis_tuser = 1'b0; // [0] first_byte
    logic         s_axis_tlast = 1'b0; // last_byte
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [31:0] obj_handle, [63:32] obj_qualifiers, [95:64] obj_length, [96] msb_first,
    // [104:97] payload_byte, [136:105] entry_handle, [138:137] error_code
    logic [143:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;        // [1:0] event_kind
    logic         m_axis_tlast;        // payload_last

    deframe_scoreboard sb;
    t_image_byte       image_bytes[$];
    bit                calm_in = 1'b0;
    bit                calm_out = 1'b0;
    bit                hold_off_req = 1'b0;
    int unsigned       cycle_count = 0;

    bytecode_container_deframer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void push_byte(logic [7:0] d, bit first_mark, bit last_mark);
        t_image_byte item;
        item.data = d;
        item.first_mark = first_mark;
        item.last_mark = last_mark;
        image_bytes.push_back(item);
    endfunction

    function automatic void push_word(logic [31:0] w, bit be, bit first_mark, bit last_mark);
        int k;
        for (k = 0; k < 4; k++) begin
            push_byte(be ? w[31-8*k -: 8] : w[8*k +: 8], first_mark && k == 0,
                      last_mark && k == 3);
        end
    endfunction

    function automatic logic [31:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2) return 32'd0;
        if (r < 9) return $urandom_range(1, 6);
        return $urandom_range(16, 40);
    endfunction

    // one image in the given shape, in an order its unit tag allows where possible
    function automatic void add_image(t_image_shape shape);
        int unsigned start, n_rec, bad_at, r, k, pay_count, cut;
        logic [31:0] len_word;
        bit          be, huge;
        start = image_bytes.size();
        be = bit'($urandom_range(0, 1));
        if (be && sb.tags.unit_tag[31:24] != ASCII_T) be = 1'b0;
        if (!be && sb.tags.unit_tag[7:0] == ASCII_T) be = 1'b1;
        huge = (shape == SHAPE_CUT) && ($urandom_range(0, 2) == 0);
        n_rec = huge ? 1 : $urandom_range(0, 3);
        bad_at = $urandom_range(0, n_rec);

        push_word((shape == SHAPE_BAD_UNIT) ? $urandom() : sb.tags.unit_tag, be, 1'b1, 1'b0);
        push_word($urandom(), be, 1'b0, 1'b0);
        push_word($urandom(), be, 1'b0, 1'b0);
        for (r = 0; r <= n_rec; r++) begin
            if (shape == SHAPE_BAD_RECORD && r == bad_at) push_word($urandom(), be, 1'b0, 1'b0);
            if (r < n_rec) begin
                push_word(sb.tags.object_tag, be, 1'b0, 1'b0);
                push_word($urandom(), be, 1'b0, 1'b0);
                push_word($urandom(), be, 1'b0, 1'b0);
                // a huge length is cut off inside its payload
                if (huge) len_word = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom();
                else len_word = pick_length();
                push_word(len_word, be, 1'b0, 1'b0);
                pay_count = huge ? 6 : len_word;
                for (k = 0; k < pay_count; k++) begin
                    push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
            end
        end
        if (!huge) push_word(sb.tags.end_tag, be, 1'b0, 1'b0);

        case (shape)
            SHAPE_CUT: begin
                if (!huge) begin
                    cut = $urandom_range(1, image_bytes.size() - start);
                    while (image_bytes.size() > start + cut) void'(image_bytes.pop_back());
                end
                image_bytes[image_bytes.size()-1].last_mark = 1'b1;
            end
            SHAPE_ABANDONED: begin
                // left unfinished; the next first byte restarts parsing
                cut = $urandom_range(1, image_bytes.size() - start - 1);
                while (image_bytes.size() > start + cut) void'(image_bytes.pop_back());
            end
            default: begin
                if ($urandom_range(0, 3) != 0) image_bytes[image_bytes.size()-1].last_mark = 1'b1;
            end
        endcase
    endfunction

    // stray bytes, mostly outside any image
    function automatic void add_noise();
        int unsigned n, k;
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
                      $urandom_range(0, 3) == 0);
        end
    endfunction

    function automatic t_cfg tag_setting(int unsigned idx);
        t_cfg c;
        c.unit_tag = $urandom();
        c.unit_tag[31:24] = ASCII_T;
        c.object_tag = $urandom();
        c.end_tag = $urandom();
        case (idx)
            2: begin
                c.unit_tag = 32'hFFFF_FFFF;
                c.object_tag = 32'h0000_0000;
                c.end_tag = 32'hFFFF_FFFF;
            end
            3: begin
                c.unit_tag = 32'h0000_0000;
                c.object_tag = 32'hFFFF_FFFF;
                c.end_tag = 32'h0000_0000;
            end
            4: c.end_tag = c.object_tag;
            5: c.unit_tag = {4{ASCII_T}};
            default: ;
        endcase
        return c;
    endfunction

    // apb write followed by a readback of the same register
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_tag(idx, value);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.compare_field("register readback", value, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_tags(t_cfg c);
        write_reg(REG_UNIT_TAG, c.unit_tag);
        write_reg(REG_OBJECT_TAG, c.object_tag);
        write_reg(REG_END_TAG, c.end_tag);
    endtask

    // offer queued bytes with random gaps; valid stays high between back-to-back items
    task automatic play_bytes();
        t_image_byte item;
        int unsigned gap;
        while (image_bytes.size() != 0) begin
            item = image_bytes.pop_front();
            gap = pick_gap(calm_in);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= item.data;
            s_axis_tuser <= item.first_mark;
            s_axis_tlast <= item.last_mark;
            do @(posedge i_clk); while (!s_axis_tready);
        end
    endtask

    task automatic stream_pause();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_events();
        while (sb.expected_events.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (calm_out || $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat (pick_gap(1'b0) + 1) @(posedge i_clk);
            end
        end
    end

    // handshake monitor: results first, then the byte taken at the same edge
    always @(posedge i_clk) begin : monitor
        t_result got;
        if (m_axis_tvalid && m_axis_tready) begin
            got.kind = t_event_kind'(m_axis_tuser);
            got.obj_handle = m_axis_tdata[31:0];
            got.obj_qualifiers = m_axis_tdata[63:32];
            got.obj_length = m_axis_tdata[95:64];
            got.msb_first = m_axis_tdata[96];
            got.payload_byte = m_axis_tdata[104:97];
            got.payload_last = m_axis_tlast;
            got.entry_handle = m_axis_tdata[136:105];
            got.error_code = t_err_code'(m_axis_tdata[138:137]);
            sb.check_event(got);
        end
        if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("bytecode_container_deframer regression: fail");
        $finish;
    end

    initial begin : stimulus
        t_cfg         dir_tags;
        int unsigned  setting, phase_bytes, pick;
        bit           paused;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, order detection, truncation, ignored bytes
        dir_tags.unit_tag = 32'h7462_6301;
        dir_tags.object_tag = 32'h6F62_6A00;
        dir_tags.end_tag = 32'h656E_6400;
        apply_tags(dir_tags);
        push_word(dir_tags.unit_tag, 1'b0, 1'b1, 1'b0);  // little endian, no records
        push_word(32'h0000_FFFF, 1'b0, 1'b0, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        push_word(dir_tags.end_tag, 1'b0, 1'b0, 1'b1);   // complete on the last byte
        push_byte(ASCII_T, 1'b1, 1'b1);                  // lone byte, first and last
        push_byte(8'h00, 1'b0, 1'b0);                    // ignored after an error
        push_word(32'h7400_0000, 1'b1, 1'b1, 1'b1);      // bad unit tag on the last byte
        play_bytes();

        // random images over several tag settings
        for (setting = 0; setting < TAG_SETTINGS; setting++) begin
            stream_pause();
            drain_events();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            apply_tags(tag_setting(setting));
            if (setting == 1) hold_off_req = 1'b1;
            phase_bytes = 0;
            paused = 1'b0;
            while (phase_bytes < PHASE_BYTES) begin
                calm_in = ($urandom_range(0, 4) == 0);
                calm_out = ($urandom_range(0, 4) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    add_noise();
                end else begin
                    if (pick < 55) add_image(SHAPE_CLEAN);
                    else if (pick < 67) add_image(SHAPE_CUT);
                    else if (pick < 76) add_image(SHAPE_BAD_UNIT);
                    else if (pick < 85) add_image(SHAPE_BAD_RECORD);
                    else add_image(SHAPE_ABANDONED);
                    phase_bytes += image_bytes.size();
                end
                play_bytes();
                // sender waits mid-phase until every event is out
                if (!paused && phase_bytes >= PHASE_BYTES / 2) begin
                    paused = 1'b1;
                    stream_pause();
                    drain_events();
                end
            end
        end

        stream_pause();
        drain_events();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_events.size() == 0) begin
            $display("bytecode_container_deframer regression: pass");
        end else begin
            $display("bytecode_container_deframer regression: fail");
        end
        $finish;
    end

endmodule
